### sv/lswf_pkg.sv
// Shared types and constants of the laser sector wall follower.
package lswf_pkg;

  // Scan geometry
  localparam int unsigned SCAN_POINTS = 360;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned RANGE_W     = 16;

  // Sector bounds in sample indices
  localparam logic [IDX_W-1:0] RIGHT_LO = IDX_W'(200);
  localparam logic [IDX_W-1:0] RIGHT_HI = IDX_W'(340);
  localparam logic [IDX_W-1:0] LEFT_LO  = IDX_W'(20);
  localparam logic [IDX_W-1:0] LEFT_HI  = IDX_W'(160);
  localparam logic [IDX_W-1:0] FRONT_HI = IDX_W'(30);
  localparam logic [IDX_W-1:0] FRONT_LO = IDX_W'(330);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCAN_POINTS - 1);

  localparam logic [RANGE_W-1:0] NO_RETURN = '1;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Motion modes
  localparam logic [1:0] MODE_FWD   = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  // Register map (index = byte address / 4)
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_WALL      = 3'd0;
  localparam logic [2:0] REG_TOL       = 3'd1;
  localparam logic [2:0] REG_FWD_HOLD  = 3'd2;
  localparam logic [2:0] REG_TURN_TICK = 3'd3;
  localparam logic [2:0] REG_TURN_RATE = 3'd4;
  localparam logic [2:0] REG_FWD_SPEED = 3'd5;

  typedef struct packed {
    logic [11:0] wall_distance_mm;
    logic [9:0]  tolerance_mm;
    logic [7:0]  forward_hold_ticks;
    logic [7:0]  turn_ticks;
    logic [10:0] turn_rate_mrad_s;
    logic [9:0]  forward_speed_mm_s;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] front;
    logic [RANGE_W-1:0] right;
    logic [RANGE_W-1:0] left;
  } sector_min_t;

  typedef struct packed {
    logic [11:0] angular;
    logic [1:0]  mode;
  } tick_res_t;

endpackage

### sv/lswf_req_if.sv
// Request channel: range samples and control ticks.
interface lswf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [8:0]  sample_index;
  logic [15:0] range_mm;
  logic        scan_end;

  modport source (output valid, req_type, sample_index, range_mm, scan_end, input ready);
  modport sink   (input valid, req_type, sample_index, range_mm, scan_end, output ready);
endinterface

### sv/lswf_rsp_if.sv
// Result channel: motion commands and latched sector minimums.
interface lswf_rsp_if;
  logic               valid;
  logic               ready;
  logic [9:0]         linear_speed_mm_s;
  logic signed [11:0] angular_rate_mrad_s;
  logic [1:0]         motion_mode;
  logic [15:0]        front_min_mm;
  logic [15:0]        right_min_mm;
  logic [15:0]        left_min_mm;

  modport source (output valid, linear_speed_mm_s, angular_rate_mrad_s, motion_mode,
                  front_min_mm, right_min_mm, left_min_mm, input ready);
  modport sink   (input valid, linear_speed_mm_s, angular_rate_mrad_s, motion_mode,
                  front_min_mm, right_min_mm, left_min_mm, output ready);
endinterface

### sv/lswf_sector_min.sv
// Running and latched per-sector range minimums over a scan.
module lswf_sector_min (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_en_i,
  input  logic [lswf_pkg::IDX_W-1:0]   sample_index_i,
  input  logic [lswf_pkg::RANGE_W-1:0] range_mm_i,
  input  logic                         scan_end_i,
  output lswf_pkg::sector_min_t        latched_o
);
  import lswf_pkg::*;

  sector_min_t run_q, run_d, cand;
  sector_min_t lat_q, lat_d;
  logic        hit_valid;
  logic        in_right, in_left, in_front;

  // Sector membership of the sample
  always_comb begin
    hit_valid = (range_mm_i != '0) && (sample_index_i <= IDX_LAST);
    in_right  = (sample_index_i >= RIGHT_LO) && (sample_index_i <= RIGHT_HI);
    in_left   = (sample_index_i >= LEFT_LO) && (sample_index_i <= LEFT_HI);
    in_front  = (sample_index_i <= FRONT_HI) ||
                ((sample_index_i >= FRONT_LO) && (sample_index_i <= IDX_LAST));
  end

  // Minimum including this sample
  always_comb begin
    cand = run_q;
    if (hit_valid && in_front && (range_mm_i < run_q.front)) cand.front = range_mm_i;
    if (hit_valid && in_right && (range_mm_i < run_q.right)) cand.right = range_mm_i;
    if (hit_valid && in_left && (range_mm_i < run_q.left)) cand.left = range_mm_i;
  end

  // End of scan latches and restarts
  always_comb begin
    run_d = run_q;
    lat_d = lat_q;
    if (sample_en_i) begin
      if (scan_end_i) begin
        lat_d = cand;
        run_d = '{front: NO_RETURN, right: NO_RETURN, left: NO_RETURN};
      end else begin
        run_d = cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '{front: NO_RETURN, right: NO_RETURN, left: NO_RETURN};
      lat_q <= '0;
    end else begin
      run_q <= run_d;
      lat_q <= lat_d;
    end
  end

  assign latched_o = lat_q;
endmodule

### sv/lswf_follower.sv
// Three-mode wall follower: forward, timed left turn, timed right turn.
module lswf_follower (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_en_i,
  input  lswf_pkg::cfg_t        cfg_i,
  input  lswf_pkg::sector_min_t mins_i,
  output lswf_pkg::tick_res_t   res_o
);
  import lswf_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic [7:0]  elapsed_q, elapsed_d;
  logic [12:0] hi_bound;
  logic        lo_neg;
  logic [11:0] lo_bound;
  logic        right_far, right_near, left_near;
  logic [11:0] rate_ext;

  // Distance band around the wall target
  always_comb begin
    hi_bound   = {1'b0, cfg_i.wall_distance_mm} + 13'(cfg_i.tolerance_mm);
    lo_neg     = 12'(cfg_i.tolerance_mm) > cfg_i.wall_distance_mm;
    lo_bound   = cfg_i.wall_distance_mm - 12'(cfg_i.tolerance_mm);
    right_far  = mins_i.right > 16'(hi_bound);
    right_near = !lo_neg && (mins_i.right < 16'(lo_bound));
    left_near  = !lo_neg && (mins_i.left < 16'(lo_bound));
    rate_ext   = {1'b0, cfg_i.turn_rate_mrad_s};
  end

  // Mode decision
  always_comb begin
    mode_d      = mode_q;
    res_o.angular = '0;
    unique case (mode_q)
      MODE_LEFT, MODE_RIGHT: begin
        if (elapsed_q < cfg_i.turn_ticks) begin
          res_o.angular = (mode_q == MODE_LEFT) ? rate_ext : (12'd0 - rate_ext);
        end else begin
          mode_d = MODE_FWD;
        end
      end
      default: begin
        mode_d = MODE_FWD;
        if (elapsed_q >= cfg_i.forward_hold_ticks) begin
          if (right_far || left_near) begin
            mode_d = MODE_RIGHT;
          end else if (right_near) begin
            mode_d = MODE_LEFT;
          end
        end
      end
    endcase
    res_o.mode = mode_d;
  end

  // Tick counter: clears on a mode change, saturates
  always_comb begin
    if (mode_d != mode_q) begin
      elapsed_d = '0;
    end else if (elapsed_q != '1) begin
      elapsed_d = elapsed_q + 8'd1;
    end else begin
      elapsed_d = elapsed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_FWD;
      elapsed_q <= '0;
    end else if (tick_en_i) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
    end
  end
endmodule

### sv/laser_sector_wall_follower_top.sv
// Top level of the laser sector wall follower.
//
// Range samples (req_type 0) update running minimums of the front, right and
// left sectors; a sample with scan_end set latches them. Control ticks
// (req_type 1) run the wall follower and return one result with the speed and
// turn command, the new mode and the latched minimums; samples return nothing.
// A request lands in an input register and is resolved from there by the
// compare logic once it can retire; a tick result is registered in an output
// register. The rate is one request per cycle, limited only by back pressure
// on the result channel. Registers are written over APB at byte address
// 4*index and must only change while the block idles.
module laser_sector_wall_follower_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lswf_req_if.sink                    req_i,
  lswf_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lswf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lswf_pkg::*;

  cfg_t        cfg_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  logic        s1_valid_q;
  logic        s1_type_q;
  logic [8:0]  s1_index_q;
  logic [15:0] s1_range_q;
  logic        s1_end_q;
  logic        s1_go, out_free;

  logic        rsp_valid_q;
  tick_res_t   tick_res;
  sector_min_t mins;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{wall_distance_mm: 12'd200, tolerance_mm: 10'd50,
                 forward_hold_ticks: 8'd20, turn_ticks: 8'd4,
                 turn_rate_mrad_s: 11'd400, forward_speed_mm_s: 10'd100};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WALL:      cfg_q.wall_distance_mm   <= pwdata[11:0];
        REG_TOL:       cfg_q.tolerance_mm       <= pwdata[9:0];
        REG_FWD_HOLD:  cfg_q.forward_hold_ticks <= pwdata[7:0];
        REG_TURN_TICK: cfg_q.turn_ticks         <= pwdata[7:0];
        REG_TURN_RATE: cfg_q.turn_rate_mrad_s   <= pwdata[10:0];
        REG_FWD_SPEED: cfg_q.forward_speed_mm_s <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_WALL:      prdata = 32'(cfg_q.wall_distance_mm);
      REG_TOL:       prdata = 32'(cfg_q.tolerance_mm);
      REG_FWD_HOLD:  prdata = 32'(cfg_q.forward_hold_ticks);
      REG_TURN_TICK: prdata = 32'(cfg_q.turn_ticks);
      REG_TURN_RATE: prdata = 32'(cfg_q.turn_rate_mrad_s);
      REG_FWD_SPEED: prdata = 32'(cfg_q.forward_speed_mm_s);
      default:       prdata = '0;
    endcase
  end

  // Flow control: a sample always retires, a tick needs a free output slot
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign s1_go       = s1_valid_q && ((s1_type_q == REQ_SAMPLE) || out_free);
  assign req_i.ready = !s1_valid_q || s1_go;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_type_q  <= req_i.req_type;
      s1_index_q <= req_i.sample_index;
      s1_range_q <= req_i.range_mm;
      s1_end_q   <= req_i.scan_end;
    end
  end

  lswf_sector_min u_sector_min (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_en_i    (s1_go && (s1_type_q == REQ_SAMPLE)),
    .sample_index_i (s1_index_q),
    .range_mm_i     (s1_range_q),
    .scan_end_i     (s1_end_q),
    .latched_o      (mins)
  );

  lswf_follower u_follower (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_en_i (s1_go && (s1_type_q == REQ_TICK)),
    .cfg_i     (cfg_q),
    .mins_i    (mins),
    .res_o     (tick_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_go && (s1_type_q == REQ_TICK)) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && (s1_type_q == REQ_TICK)) begin
      rsp_o.linear_speed_mm_s   <= cfg_q.forward_speed_mm_s;
      rsp_o.angular_rate_mrad_s <= $signed(tick_res.angular);
      rsp_o.motion_mode         <= tick_res.mode;
      rsp_o.front_min_mm        <= mins.front;
      rsp_o.right_min_mm        <= mins.right;
      rsp_o.left_min_mm         <= mins.left;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
endmodule

### verif/lswf_motion_checker.sv
// Checker for the wall follower: tracks registers, predicts tick commands, compares results.
`timescale 1ns / 1ps
module lswf_motion_checker
  import lswf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  lswf_req_if               req_i,
  lswf_rsp_if               rsp_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [9:0]  speed;
    logic [11:0] angular;
    logic [1:0]  mode;
    sector_min_t mins;
  } motion_cmd_t;

  localparam cfg_t CFG_RESET = '{12'd200, 10'd50, 8'd20, 8'd4, 11'd400, 10'd100};

  // Shadow of the block's registers and follower state
  cfg_t        cfg;
  logic [1:0]  motion_mode;
  logic [7:0]  elapsed;
  sector_min_t latched_min;
  sector_min_t running_min;
  motion_cmd_t cmd_expect_q[$];
  motion_cmd_t head;

  // Fold one range sample into the running sector minimums
  function automatic void fold_range_sample(logic [8:0] idx, logic [15:0] r, logic last);
    if (r != '0 && idx < SCAN_POINTS) begin
      if (idx >= RIGHT_LO && idx <= RIGHT_HI && r < running_min.right)
        running_min.right = r;
      if (idx >= LEFT_LO && idx <= LEFT_HI && r < running_min.left)
        running_min.left = r;
      if ((idx <= FRONT_HI || (idx >= FRONT_LO && idx <= IDX_LAST)) && r < running_min.front)
        running_min.front = r;
    end
    // end of scan latches, this sample included
    if (last) begin
      latched_min = running_min;
      running_min = '1;
    end
  endfunction

  // One control tick of the follower; returns the command it answers with
  function automatic motion_cmd_t follow_wall_tick();
    int          hi, lo, right, left;
    logic [1:0]  nxt;
    logic [11:0] ang;
    motion_cmd_t c;
    hi    = int'(cfg.wall_distance_mm) + int'(cfg.tolerance_mm);
    lo    = int'(cfg.wall_distance_mm) - int'(cfg.tolerance_mm);
    right = int'(latched_min.right);
    left  = int'(latched_min.left);
    nxt   = motion_mode;
    ang   = '0;
    if (motion_mode == MODE_LEFT || motion_mode == MODE_RIGHT) begin
      if (elapsed < cfg.turn_ticks) begin
        ang = (motion_mode == MODE_LEFT) ? 12'(cfg.turn_rate_mrad_s)
                                         : 12'(-int'(cfg.turn_rate_mrad_s));
      end else begin
        nxt = MODE_FWD;
      end
    end else begin
      nxt = MODE_FWD;
      if (elapsed >= cfg.forward_hold_ticks) begin
        if (right > hi || left < lo) nxt = MODE_RIGHT;
        else if (right < lo) nxt = MODE_LEFT;
      end
    end
    // counter clears on a mode change, else saturates
    if (nxt != motion_mode) elapsed = '0;
    else if (elapsed != 8'hFF) elapsed = elapsed + 8'd1;
    motion_mode = nxt;
    c.speed   = cfg.forward_speed_mm_s;
    c.angular = ang;
    c.mode    = motion_mode;
    c.mins    = latched_min;
    return c;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg          = CFG_RESET;
      motion_mode  = MODE_FWD;
      elapsed      = '0;
      latched_min  = '0;
      running_min  = '1;
      cmd_expect_q.delete();
      fail_count_o = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_WALL:      cfg.wall_distance_mm   = pwdata[11:0];
          REG_TOL:       cfg.tolerance_mm       = pwdata[9:0];
          REG_FWD_HOLD:  cfg.forward_hold_ticks = pwdata[7:0];
          REG_TURN_TICK: cfg.turn_ticks         = pwdata[7:0];
          REG_TURN_RATE: cfg.turn_rate_mrad_s   = pwdata[10:0];
          REG_FWD_SPEED: cfg.forward_speed_mm_s = pwdata[9:0];
          default: ;
        endcase
      end
      // results against the oldest expectation
      if (rsp_i.valid && rsp_i.ready) begin
        if (cmd_expect_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          head = cmd_expect_q.pop_front();
          if (rsp_i.linear_speed_mm_s !== head.speed)
            report_mismatch("linear_speed_mm_s", int'(rsp_i.linear_speed_mm_s),
                            int'(head.speed));
          if (rsp_i.angular_rate_mrad_s !== head.angular)
            report_mismatch("angular_rate_mrad_s", int'(rsp_i.angular_rate_mrad_s),
                            int'($signed(head.angular)));
          if (rsp_i.motion_mode !== head.mode)
            report_mismatch("motion_mode", int'(rsp_i.motion_mode), int'(head.mode));
          if (rsp_i.front_min_mm !== head.mins.front)
            report_mismatch("front_min_mm", int'(rsp_i.front_min_mm), int'(head.mins.front));
          if (rsp_i.right_min_mm !== head.mins.right)
            report_mismatch("right_min_mm", int'(rsp_i.right_min_mm), int'(head.mins.right));
          if (rsp_i.left_min_mm !== head.mins.left)
            report_mismatch("left_min_mm", int'(rsp_i.left_min_mm), int'(head.mins.left));
        end
      end
      // accepted requests
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == REQ_TICK)
          cmd_expect_q.push_back(follow_wall_tick());
        else
          fold_range_sample(req_i.sample_index, req_i.range_mm, req_i.scan_end);
      end
    end
    pending_o = cmd_expect_q.size();
  end

endmodule

### verif/laser_sector_wall_follower_top_tb.sv
// Testbench top: drives samples, ticks and register writes into the wall follower.
`timescale 1ns / 1ps
module laser_sector_wall_follower_top_tb;
  import lswf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned FILL_TICKS    = 40;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned items_sent;
  bit          calm;
  bit          long_hold_go;
  cfg_t        cur_cfg;

  lswf_req_if req_if ();
  lswf_rsp_if rsp_if ();

  laser_sector_wall_follower_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lswf_motion_checker motion_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("laser_sector_wall_follower_top verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold on request
  initial begin : rsp_ready_drv
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19);
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until taken; maybe idle afterwards
  task automatic offer(input logic kind, input logic [8:0] idx, input logic [15:0] r,
                       input logic last);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.sample_index <= idx;
    req_if.range_mm     <= r;
    req_if.scan_end     <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Sample fields on a tick are don't-care, so randomize them
  task automatic offer_tick();
    offer(REQ_TICK, 9'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Wait for every expected result, then let in-flight samples settle
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Optionally set bits above the register width; the block must drop them
  function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned w, bit junk);
    if (junk && $urandom_range(0, 3) == 0) return v | ($urandom() << w);
    return v;
  endfunction

  task automatic load_cfg(input cfg_t c, input bit junk);
    cur_cfg = c;
    apb_write(REG_WALL,      with_junk(32'(c.wall_distance_mm), 12, junk));
    apb_write(REG_TOL,       with_junk(32'(c.tolerance_mm), 10, junk));
    apb_write(REG_FWD_HOLD,  with_junk(32'(c.forward_hold_ticks), 8, junk));
    apb_write(REG_TURN_TICK, with_junk(32'(c.turn_ticks), 8, junk));
    apb_write(REG_TURN_RATE, with_junk(32'(c.turn_rate_mrad_s), 11, junk));
    apb_write(REG_FWD_SPEED, with_junk(32'(c.forward_speed_mm_s), 10, junk));
    // unmapped slots are ignored
    apb_write(REG_SPARE_LO, $urandom());
    apb_write(REG_SPARE_HI, $urandom());
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.wall_distance_mm   = 12'($urandom_range(100, 3000));
    c.tolerance_mm       = 10'($urandom_range(0, 400));
    c.forward_hold_ticks = 8'($urandom_range(0, 5));
    c.turn_ticks         = 8'($urandom_range(0, 6));
    c.turn_rate_mrad_s   = 11'($urandom_range(0, 2000));
    c.forward_speed_mm_s = 10'($urandom_range(0, 1000));
    return c;
  endfunction

  // Mostly in-scan indices, some past the end of the scan
  function automatic logic [8:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 9'($urandom_range(SCAN_POINTS, 511));
    return 9'($urandom_range(0, SCAN_POINTS - 1));
  endfunction

  // Ranges cluster around the wall band so every decision gets taken
  function automatic logic [15:0] pick_range();
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return NO_RETURN;
      2: return 16'($urandom);
      default: begin
        v = int'(cur_cfg.wall_distance_mm) - 2 * int'(cur_cfg.tolerance_mm)
            + int'($urandom_range(0, 4 * cur_cfg.tolerance_mm + 2));
        if (v < 1) v = 1;
        if (v > 65535) v = 65535;
        return 16'(v);
      end
    endcase
  endfunction

  // Short scans with ticks mixed in, plus some raw noise
  task automatic run_phase(input int unsigned n);
    int unsigned goal, k, j;
    goal = items_sent + n;
    while (items_sent < goal) begin
      if ($urandom_range(0, 6) != 0) begin
        k = $urandom_range(2, 18);
        for (j = 0; j < k; j++) begin
          if ($urandom_range(0, 3) == 0) offer_tick();
          offer(REQ_SAMPLE, pick_index(), pick_range(), j == k - 1);
        end
        repeat ($urandom_range(1, 4)) offer_tick();
      end else begin
        offer(1'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_SAMPLE;
    req_if.sample_index <= '0;
    req_if.range_mm     <= '0;
    req_if.scan_end     <= 1'b0;
    cur_cfg = '{12'd200, 10'd50, 8'd20, 8'd4, 11'd400, 10'd100};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, nothing latched yet
    offer_tick();
    offer_tick();
    drain();

    // directed: decide at once, short turns
    load_cfg('{12'd200, 10'd50, 8'd0, 8'd2, 11'd400, 10'd100}, 1'b0);
    offer_tick();                              // zero minimums read as near
    offer_tick();
    offer(REQ_SAMPLE, 9'd0,   16'd1000,  1'b0);
    offer(REQ_SAMPLE, 9'd30,  16'd900,   1'b0);
    offer(REQ_SAMPLE, 9'd330, 16'd800,   1'b0);
    offer(REQ_SAMPLE, 9'd359, 16'd700,   1'b0);
    offer(REQ_SAMPLE, 9'd360, 16'd3,     1'b0); // past the scan, no sector
    offer(REQ_SAMPLE, 9'd511, 16'd2,     1'b0);
    offer(REQ_SAMPLE, 9'd200, 16'd600,   1'b0);
    offer(REQ_SAMPLE, 9'd340, 16'd500,   1'b0);
    offer(REQ_SAMPLE, 9'd199, 16'd4,     1'b0);
    offer(REQ_SAMPLE, 9'd341, 16'd6,     1'b0);
    offer(REQ_SAMPLE, 9'd20,  16'hFFFF,  1'b0);
    offer(REQ_SAMPLE, 9'd160, 16'd400,   1'b0);
    offer(REQ_SAMPLE, 9'd19,  16'd7,     1'b0);
    offer(REQ_SAMPLE, 9'd100, 16'd0,     1'b0); // no return
    offer(REQ_SAMPLE, 9'd250, 16'hFFFF,  1'b0);
    offer(REQ_TICK,   9'd250, 16'd1,     1'b1); // scan mark on a tick is ignored
    offer(REQ_SAMPLE, 9'd400, 16'd9,     1'b1); // out-of-scan sample still latches
    repeat (4) offer_tick();
    offer(REQ_SAMPLE, 9'd250, 16'd0,     1'b1); // empty scan: all sectors far
    repeat (3) offer_tick();
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: load_cfg('0, 1'b0);
        1: load_cfg('{12'hFFF, 10'h3FF, 8'hFF, 8'hFF, 11'h7FF, 10'h3FF}, 1'b0);
        2: load_cfg('{12'd100, 10'd600, 8'd1, 8'd2, 11'd1500, 10'd300}, 1'b0);
        default: load_cfg(random_cfg(), 1'b1);
      endcase
      if (p == 3) begin
        // result side blocked while ticks keep coming: the block backs up
        calm = 1'b1;
        long_hold_go = 1'b1;
        repeat (FILL_TICKS) offer_tick();
        calm = 1'b0;
      end
      if (p == 5) calm = 1'b1;
      if (p == 4) begin
        run_phase(PHASE_ITEMS / 2);
        drain();
        run_phase(PHASE_ITEMS / 2);
      end else begin
        run_phase(PHASE_ITEMS);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("laser_sector_wall_follower_top verification clean");
    end else begin
      $display("laser_sector_wall_follower_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
sv/lswf_pkg.sv
sv/lswf_req_if.sv
sv/lswf_rsp_if.sv
sv/lswf_sector_min.sv
sv/lswf_follower.sv
sv/laser_sector_wall_follower_top.sv
verif/lswf_motion_checker.sv
verif/laser_sector_wall_follower_top_tb.sv
